// ===== src/mvdm_pkg.sv =====
// Shared types and constants for the metric vector duplicate matcher.
// Used by the controller, the datapath and the top level; no dependencies.
package mvdm_pkg;

    // Input item: seven metrics, each carried in a 16-bit slot of s_tdata
    localparam int NUM_METRICS  = 7;
    localparam int IN_METRIC_W  = 16;
    localparam int S_TDATA_W    = NUM_METRICS * IN_METRIC_W;

    // Result item: two 6-bit indices in m_tdata, padded to two bytes
    localparam int IDX_OUT_W    = 6;
    localparam int M_TDATA_W    = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // take the accepted item into the working registers
        logic scan;     // walk the stored vectors
        logic flush;    // send the held match as the final result
        logic store;    // write the vector and bump the count
        logic reject;   // send a single rejection result
    } mvdm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;       // store holds the maximum number of vectors
        logic scan_done;  // all stored vectors read and compared
        logic pend_valid; // a match is held back for last marking
        logic out_free;   // output register can take a result this cycle
    } mvdm_sts_t;

endpackage

// ===== src/mvdm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module mvdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data when not enabled
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/mvdm_ctrl.sv =====
// Controller state machine for the duplicate matcher.
// Depends on mvdm_pkg for the command and status structs.
module mvdm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mvdm_pkg::mvdm_sts_t sts,
    output mvdm_pkg::mvdm_cmd_t cmd
);
    import mvdm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_REJECT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.full) begin
                    state_next = ST_REJECT;
                end else begin
                    cmd.scan = 1'b1;
                    if (sts.scan_done) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.store  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REJECT: begin
                cmd.reject = 1'b1;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mvdm_dp.sv =====
// Datapath for the duplicate matcher: vector store, scan pipeline, match
// hold register and output register. Depends on mvdm_pkg and mvdm_ram.
module mvdm_dp #(
    parameter int MAX_METHODS = 64,
    parameter int METRIC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mvdm_pkg::mvdm_cmd_t               cmd,
    output mvdm_pkg::mvdm_sts_t               sts,
    input  logic [mvdm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mvdm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import mvdm_pkg::*;

    // Metrics are cut to 16 bits on input, then to METRIC_BITS if narrower
    localparam int KEEP_BITS = (METRIC_BITS < IN_METRIC_W) ? METRIC_BITS : IN_METRIC_W;
    localparam int VEC_W     = NUM_METRICS * KEEP_BITS;
    localparam int IDX_W     = (MAX_METHODS > 1) ? $clog2(MAX_METHODS) : 1;
    localparam int CNT_W     = $clog2(MAX_METHODS + 1);

    logic [VEC_W-1:0] vec_reg;
    logic [VEC_W-1:0] vec_in;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] addr_reg;
    logic [CNT_W-1:0] addr_next;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [IDX_W-1:0] out_earlier_reg;
    logic [IDX_W-1:0] out_current_reg;
    logic             out_rej_reg;
    logic             out_last_reg;
    logic [VEC_W-1:0] rd_data;
    logic             issue;
    logic             hit;
    logic             stall;
    logic             out_free;
    logic             ld_match;
    logic             ld_flush;
    logic             ld_rej;

    // Trim the incoming metrics
    always_comb begin
        for (int m = 0; m < NUM_METRICS; m++) begin
            vec_in[m*KEEP_BITS +: KEEP_BITS] = s_tdata[m*IN_METRIC_W +: KEEP_BITS];
        end
    end

    // Vector store
    mvdm_ram #(
        .WIDTH (VEC_W),
        .DEPTH (MAX_METHODS)
    ) u_store (
        .clk     (aclk),
        .wr_en   (cmd.store),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (vec_reg),
        .rd_en   (issue),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Scan: one read per cycle unless stalled; compare on RAM output
    assign out_free = !out_valid_reg || m_tready;
    assign hit      = cmp_valid_reg && (rd_data == vec_reg);
    assign stall    = hit && pend_valid_reg && !out_free;
    assign issue    = cmd.scan && !stall && (addr_reg < count_reg);

    // Output loads; at most one per cycle by construction
    assign ld_match = hit && pend_valid_reg && !stall;
    assign ld_flush = cmd.flush && pend_valid_reg && out_free;
    assign ld_rej   = cmd.reject && out_free;

    assign sts.full       = (count_reg == CNT_W'(MAX_METHODS));
    assign sts.scan_done  = (addr_reg == count_reg) && !cmp_valid_reg;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // Next-state for control registers
    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_tuser) begin
            count_next = '0;
        end else if (cmd.store) begin
            count_next = count_reg + CNT_W'(1);
        end

        addr_next = addr_reg;
        if (cmd.load) begin
            addr_next = '0;
        end else if (issue) begin
            addr_next = addr_reg + CNT_W'(1);
        end

        cmp_valid_next = stall ? cmp_valid_reg : issue;

        pend_valid_next = pend_valid_reg;
        if (ld_flush || cmd.load) begin
            pend_valid_next = 1'b0;
        end else if (hit && !stall) begin
            pend_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg && !m_tready;
        if (ld_match || ld_flush || ld_rej) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            addr_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            addr_reg       <= addr_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vec_reg <= vec_in;
        end
        if (issue) begin
            cmp_idx_reg <= addr_reg[IDX_W-1:0];
        end
        if (hit && !stall) begin
            pend_idx_reg <= cmp_idx_reg;
        end
        if (ld_match || ld_flush) begin
            out_earlier_reg <= pend_idx_reg;
            out_current_reg <= count_reg[IDX_W-1:0];
            out_rej_reg     <= 1'b0;
            out_last_reg    <= ld_flush;
        end else if (ld_rej) begin
            out_earlier_reg <= '0;
            out_current_reg <= '0;
            out_rej_reg     <= 1'b1;
            out_last_reg    <= 1'b1;
        end
    end

    // Result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*IDX_OUT_W)'(0),
                       IDX_OUT_W'(out_current_reg),
                       IDX_OUT_W'(out_earlier_reg)};
    assign m_tuser  = out_rej_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/metric_vector_duplicate_matcher_core.sv =====
// Top level of the metric vector duplicate matcher.
// Depends on mvdm_pkg, mvdm_ctrl, mvdm_dp and mvdm_ram.

// Each input item carries one method's seven code metrics; the block compares
// them, in stored order, with every vector stored since the last item flagged
// as first of its set, and emits one result per equal earlier vector (earlier
// index, current index), the final one marked by m_tlast, then stores the
// vector. An item finding the store full yields one result with m_tuser set
// and is not stored. The scan reads one stored vector per cycle, covering the
// N vectors stored (at most MAX_METHODS - 1), and pauses while the result
// side holds m_tready low while a match waits. Items are handled one at a
// time; s_tready is high only between items, while a finished result may
// still sit in the output register.
module metric_vector_duplicate_matcher_core #(
    parameter int MAX_METHODS = 64,
    parameter int METRIC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // line_count, if_count, complexity, return_count, argument_count,
    // local_count, call_count; 16 bits each from bit 0 up
    input  logic [mvdm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,   // first_of_set
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // earlier_index [5:0], current_index [11:6], zero [15:12]
    output logic [mvdm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // rejected
    output logic                           m_tlast    // last_match
);
    import mvdm_pkg::*;

    mvdm_cmd_t cmd;
    mvdm_sts_t sts;

    mvdm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mvdm_dp #(
        .MAX_METHODS (MAX_METHODS),
        .METRIC_BITS (METRIC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // A full store must never be scanned
    a_no_scan_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.scan && sts.full))
        else $error("scan issued with full store");

    // No held match survives into the next item
    a_no_pend_at_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.pend_valid)
        else $error("match still held when taking a new item");

    // A rejection is a single, final, all-zero result
    a_reject_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("malformed rejection result");

    // Match pairs always point back to an earlier index
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[5:0] < m_tdata[11:6]))
        else $error("earlier index not below current index");
`endif

endmodule
